FILE: design/pce_pkg.sv
// shared types, constants and compare helpers for the polytope chord extrema unit
// no dependencies; imported by every other design file except pce_if
package pce_pkg;

  localparam int EW = 14;  // internal signed exponent width

  localparam logic [63:0] FREE_LOW  = 64'hC08F_4000_0000_0000;  // -1000.0
  localparam logic [63:0] FREE_HIGH = 64'h408F_4000_0000_0000;  // 1000.0
  localparam logic [63:0] EXT_POS   = 64'h41CD_CD65_0000_0000;  // 1e9
  localparam logic [63:0] EXT_NEG   = 64'hC1CD_CD65_0000_0000;  // -1e9
  localparam logic [63:0] QNAN      = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;
  localparam logic [63:0] POS_ZERO  = 64'd0;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_SUB,
    FOP_DIV
  } fop_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_NORM,
    FS_MUL,
    FS_DIV,
    FS_ADD,
    FS_POST,
    FS_ROUND
  } fpu_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_V,
    BK_ADD_V,
    BK_MUL_S,
    BK_ADD_S,
    BK_ROW,
    BK_SUB_LO,
    BK_DIV_LO,
    BK_SUB_HI,
    BK_DIV_HI,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [63:0] coefficient;
    logic [63:0] point_value;
    logic [63:0] direction_value;
    logic [63:0] lower_bound;
    logic [63:0] upper_bound;
    logic        row_end;
    logic        sweep_end;
    logic        is_free;
  } pce_entry_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  function automatic logic fp_is_nan(input logic [63:0] x);
    fp_is_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  // ieee less-than: false on nan, +0 equals -0
  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic res;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
      res = 1'b0;
    end else if (a[63] != b[63]) begin
      res = a[63];
    end else if (!a[63]) begin
      res = a[62:0] < b[62:0];
    end else begin
      res = a[62:0] > b[62:0];
    end
    fp_lt = res;
  endfunction

endpackage

FILE: design/pce_if.sv
// channel interfaces of the polytope chord extrema unit
// depends on nothing; used by the front, back and top level
interface pce_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] coefficient;
  logic [63:0] point_value;
  logic [63:0] direction_value;
  logic        row_end;
  logic [63:0] lower_bound;
  logic [63:0] upper_bound;
  logic        sweep_end;

  modport source (
    output valid, coefficient, point_value, direction_value, row_end,
           lower_bound, upper_bound, sweep_end,
    input  ready
  );
  modport sink (
    input  valid, coefficient, point_value, direction_value, row_end,
           lower_bound, upper_bound, sweep_end,
    output ready
  );
endinterface

interface pce_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] step_forward;
  logic [63:0] step_backward;

  modport source (
    output valid, step_forward, step_backward,
    input  ready
  );
  modport sink (
    input  valid, step_forward, step_backward,
    output ready
  );
endinterface

FILE: design/pce_fpu.sv
// multi-cycle double precision unit: multiply, add, subtract, divide, round to nearest even
// depends on pce_pkg
module pce_fpu
  import pce_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  fpu_state_t state_r, state_nxt;
  fop_t op_r, op_nxt;
  logic sa_r, sa_nxt, sb_r, sb_nxt, s_r, s_nxt;
  logic sticky_r, sticky_nxt, done_r, done_nxt;
  logic signed [EW-1:0] ea_r, ea_nxt, eb_r, eb_nxt, e_r, e_nxt;
  logic [52:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [105:0] acc_r, acc_nxt;
  logic [63:0] m_r, m_nxt, res_r, res_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  // operand classes at request time
  logic [10:0] fa_e, fb_e;
  logic fsa, fsb;
  logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic spec;
  logic [63:0] spec_res;

  assign fa_e = req.a[62:52];
  assign fb_e = req.b[62:52];
  assign fsa = req.a[63];
  assign fsb = (req.op == FOP_SUB) ? ~req.b[63] : req.b[63];
  assign a_nan = fp_is_nan(req.a);
  assign b_nan = fp_is_nan(req.b);
  assign a_inf = (fa_e == 11'h7FF) && (req.a[51:0] == 52'd0);
  assign b_inf = (fb_e == 11'h7FF) && (req.b[51:0] == 52'd0);
  assign a_zero = (req.a[62:0] == 63'd0);
  assign b_zero = (req.b[62:0] == 63'd0);

  always_comb begin
    spec = 1'b1;
    spec_res = QNAN;
    case (req.op)
      FOP_MUL: begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) spec_res = QNAN;
        else if (a_inf || b_inf) spec_res = {fsa ^ fsb, INF_MAG};
        else if (a_zero || b_zero) spec_res = {fsa ^ fsb, 63'd0};
        else spec = 1'b0;
      end
      FOP_DIV: begin
        if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf)) spec_res = QNAN;
        else if (a_inf || b_zero) spec_res = {fsa ^ fsb, INF_MAG};
        else if (a_zero || b_inf) spec_res = {fsa ^ fsb, 63'd0};
        else spec = 1'b0;
      end
      default: begin
        if (a_nan || b_nan || (a_inf && b_inf && (fsa != fsb))) spec_res = QNAN;
        else if (a_inf) spec_res = {fsa, INF_MAG};
        else if (b_inf) spec_res = {fsb, INF_MAG};
        else if (a_zero && b_zero) spec_res = {fsa & fsb, 63'd0};
        else if (a_zero) spec_res = {fsb, req.b[62:0]};
        else if (b_zero) spec_res = {fsa, req.a[62:0]};
        else spec = 1'b0;
      end
    endcase
  end

  // multiply: 27x27 partial products, one per cycle
  logic [26:0] mul_a, mul_b;
  logic [53:0] pp;
  logic [105:0] pp_sh, acc_sum;
  logic [1:0] pp_pos;

  assign mul_a = cnt_r[1] ? {1'b0, ma_r[52:27]} : ma_r[26:0];
  assign mul_b = cnt_r[0] ? {1'b0, mb_r[52:27]} : mb_r[26:0];
  assign pp = mul_a * mul_b;
  assign pp_pos = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};

  // high by high product is at most 52 bits wide
  always_comb begin
    case (pp_pos)
      2'd0: pp_sh = {52'd0, pp};
      2'd1: pp_sh = {25'd0, pp, 27'd0};
      default: pp_sh = {pp[51:0], 54'd0};
    endcase
  end

  assign acc_sum = acc_r + pp_sh;

  // divide: restoring, one quotient bit per cycle
  logic div_ge;
  logic [53:0] div_diff;

  assign div_ge = acc_r[53:0] >= {1'b0, mb_r};
  assign div_diff = div_ge ? (acc_r[53:0] - {1'b0, mb_r}) : acc_r[53:0];

  // add: align smaller operand with sticky jam
  logic a_big, s_big, s_sml;
  logic signed [EW-1:0] e_big, e_sml, al_d;
  logic [52:0] m_big, m_sml;
  logic [63:0] x_big, y0, y_sh, add_sum;
  logic y_st;

  assign a_big = (ea_r > eb_r) || ((ea_r == eb_r) && (ma_r >= mb_r));
  assign e_big = a_big ? ea_r : eb_r;
  assign e_sml = a_big ? eb_r : ea_r;
  assign m_big = a_big ? ma_r : mb_r;
  assign m_sml = a_big ? mb_r : ma_r;
  assign s_big = a_big ? sa_r : sb_r;
  assign s_sml = a_big ? sb_r : sa_r;
  assign al_d = e_big - e_sml;
  assign x_big = {1'b0, m_big, 10'd0};
  assign y0 = {1'b0, m_sml, 10'd0};

  always_comb begin
    if (al_d > 14'sd63) begin
      y_sh = 64'd0;
      y_st = 1'b1;
    end else begin
      y_sh = y0 >> al_d[5:0];
      y_st = |(y0 & ~({64{1'b1}} << al_d[5:0]));
    end
  end

  assign add_sum = (s_big == s_sml) ? (x_big + (y_sh | {63'd0, y_st}))
                                    : (x_big - (y_sh | {63'd0, y_st}));

  // round and pack, with subnormal shift
  logic underflow, ovf, rs_st, lo_st, rnd_up;
  logic signed [EW-1:0] rs_amt;
  logic [63:0] rs_m, rm;
  logic [10:0] ef;
  logic [62:0] mag;

  assign underflow = e_r < 14'sd1;
  assign ovf = e_r > 14'sd2046;
  assign rs_amt = 14'sd1 - e_r;

  always_comb begin
    if (rs_amt > 14'sd63) begin
      rs_m = 64'd0;
      rs_st = |m_r;
    end else begin
      rs_m = m_r >> rs_amt[5:0];
      rs_st = |(m_r & ~({64{1'b1}} << rs_amt[5:0]));
    end
  end

  assign rm = underflow ? rs_m : m_r;
  assign ef = rm[63] ? e_r[10:0] : 11'd0;
  assign lo_st = (|rm[9:0]) | sticky_r | (underflow & rs_st);
  assign rnd_up = rm[10] & (lo_st | rm[11]);
  assign mag = {ef, rm[62:11]} + {62'd0, rnd_up};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: if (req.start && !spec) state_nxt = FS_NORM;
      FS_NORM: begin
        if (ma_r[52] && mb_r[52]) begin
          case (op_r)
            FOP_MUL: state_nxt = FS_MUL;
            FOP_DIV: state_nxt = FS_DIV;
            default: state_nxt = FS_ADD;
          endcase
        end
      end
      FS_MUL: if (cnt_r == 6'd3) state_nxt = FS_POST;
      FS_DIV: if (cnt_r == 6'd55) state_nxt = FS_POST;
      FS_ADD: state_nxt = (add_sum == 64'd0) ? FS_IDLE : FS_POST;
      FS_POST: if (m_r[63] || (e_r <= 14'sd1)) state_nxt = FS_ROUND;
      FS_ROUND: state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt = op_r;
    sa_nxt = sa_r;
    sb_nxt = sb_r;
    s_nxt = s_r;
    sticky_nxt = sticky_r;
    done_nxt = 1'b0;
    ea_nxt = ea_r;
    eb_nxt = eb_r;
    e_nxt = e_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    m_nxt = m_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    case (state_r)
      FS_IDLE: begin
        if (req.start) begin
          if (spec) begin
            res_nxt = spec_res;
            done_nxt = 1'b1;
          end else begin
            op_nxt = req.op;
            sa_nxt = fsa;
            sb_nxt = fsb;
            ea_nxt = (fa_e == 11'd0) ? 14'sd1 : $signed({3'd0, fa_e});
            eb_nxt = (fb_e == 11'd0) ? 14'sd1 : $signed({3'd0, fb_e});
            ma_nxt = {fa_e != 11'd0, req.a[51:0]};
            mb_nxt = {fb_e != 11'd0, req.b[51:0]};
          end
        end
      end
      FS_NORM: begin
        if (!ma_r[52]) begin
          if (ma_r[52:45] == 8'd0) begin
            ma_nxt = {ma_r[44:0], 8'd0};
            ea_nxt = ea_r - 14'sd8;
          end else begin
            ma_nxt = {ma_r[51:0], 1'b0};
            ea_nxt = ea_r - 14'sd1;
          end
        end
        if (!mb_r[52]) begin
          if (mb_r[52:45] == 8'd0) begin
            mb_nxt = {mb_r[44:0], 8'd0};
            eb_nxt = eb_r - 14'sd8;
          end else begin
            mb_nxt = {mb_r[51:0], 1'b0};
            eb_nxt = eb_r - 14'sd1;
          end
        end
        cnt_nxt = 6'd0;
        acc_nxt = (op_r == FOP_DIV) ? {53'd0, ma_r} : 106'd0;
        m_nxt = 64'd0;
      end
      FS_MUL: begin
        acc_nxt = acc_sum;
        cnt_nxt = cnt_r + 6'd1;
        m_nxt = acc_sum[105:42];
        sticky_nxt = |acc_sum[41:0];
        e_nxt = ea_r + eb_r - 14'sd1022;
        s_nxt = sa_r ^ sb_r;
      end
      FS_DIV: begin
        acc_nxt = {52'd0, div_diff[52:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        m_nxt = {m_r[62:0], div_ge};
        if (cnt_r == 6'd55) begin
          m_nxt = {m_r[54:0], div_ge, 8'd0};
          sticky_nxt = div_diff != 54'd0;
          e_nxt = ea_r - eb_r + 14'sd1023;
          s_nxt = sa_r ^ sb_r;
        end
      end
      FS_ADD: begin
        m_nxt = add_sum;
        sticky_nxt = 1'b0;
        e_nxt = e_big + 14'sd1;
        s_nxt = s_big;
        if (add_sum == 64'd0) begin
          res_nxt = POS_ZERO;
          done_nxt = 1'b1;
        end
      end
      FS_POST: begin
        if (!m_r[63] && (e_r > 14'sd1)) begin
          if ((m_r[63:56] == 8'd0) && (e_r > 14'sd8)) begin
            m_nxt = {m_r[55:0], 8'd0};
            e_nxt = e_r - 14'sd8;
          end else begin
            m_nxt = {m_r[62:0], 1'b0};
            e_nxt = e_r - 14'sd1;
          end
        end
      end
      FS_ROUND: begin
        res_nxt = ovf ? {s_r, INF_MAG} : {s_r, mag};
        done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    op_r <= op_nxt;
    sa_r <= sa_nxt;
    sb_r <= sb_nxt;
    s_r <= s_nxt;
    sticky_r <= sticky_nxt;
    ea_r <= ea_nxt;
    eb_r <= eb_nxt;
    e_r <= e_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    acc_r <= acc_nxt;
    m_r <= m_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res = res_r;

endmodule

FILE: design/pce_front.sv
// front part: takes input requests, flags free rows, holds them in a two-entry queue
// depends on pce_pkg and pce_in_if
module pce_front
  import pce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pce_in_if.sink      in_ch,
  input  logic        pop,
  output logic        head_valid,
  output pce_entry_t  head
);

  pce_entry_t q_r [2];
  logic wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;
  pce_entry_t entry;

  assign in_ch.ready = cnt_r != 2'd2;
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    entry.coefficient = in_ch.coefficient;
    entry.point_value = in_ch.point_value;
    entry.direction_value = in_ch.direction_value;
    entry.lower_bound = in_ch.lower_bound;
    entry.upper_bound = in_ch.upper_bound;
    entry.row_end = in_ch.row_end;
    entry.sweep_end = in_ch.sweep_end;
    entry.is_free = (in_ch.lower_bound == FREE_LOW) && (in_ch.upper_bound == FREE_HIGH);
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wr_ptr_r] <= entry;
  end

  assign head_valid = cnt_r != 2'd0;
  assign head = q_r[rd_ptr_r];

endmodule

FILE: design/pce_back.sv
// back part: sequences row sums, crossing distances and extremes through the shared fpu
// depends on pce_pkg and pce_out_if
module pce_back
  import pce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  pce_entry_t  head,
  output logic        pop,
  output fpu_req_t    req,
  input  fpu_rsp_t    rsp,
  pce_out_if.source   out_ch
);

  bk_state_t state_r, state_nxt;
  logic issued_r, issued_nxt;
  logic [63:0] val_sum_r, val_sum_nxt, slp_sum_r, slp_sum_nxt;
  logic [63:0] fwd_r, fwd_nxt, bwd_r, bwd_nxt;
  logic [63:0] prod_r, prod_nxt, tmp_r, tmp_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [63:0] out_fwd_r, out_fwd_nxt, out_bwd_r, out_bwd_nxt;

  logic out_free, hit, op_state, clear_sums, load_out;

  assign out_free = !out_valid_r || out_ch.ready;
  assign hit = !head.is_free && (slp_sum_r[62:0] != 63'd0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (head_valid) state_nxt = BK_MUL_V;
      BK_MUL_V: if (rsp.done) state_nxt = BK_ADD_V;
      BK_ADD_V: if (rsp.done) state_nxt = BK_MUL_S;
      BK_MUL_S: if (rsp.done) state_nxt = BK_ADD_S;
      BK_ADD_S: begin
        if (rsp.done) begin
          if (head.row_end) state_nxt = BK_ROW;
          else if (head.sweep_end) state_nxt = BK_EMIT;
          else state_nxt = BK_IDLE;
        end
      end
      BK_ROW: begin
        if (hit) state_nxt = BK_SUB_LO;
        else if (head.sweep_end) state_nxt = BK_EMIT;
        else state_nxt = BK_IDLE;
      end
      BK_SUB_LO: if (rsp.done) state_nxt = BK_DIV_LO;
      BK_DIV_LO: if (rsp.done) state_nxt = BK_SUB_HI;
      BK_SUB_HI: if (rsp.done) state_nxt = BK_DIV_HI;
      BK_DIV_HI: if (rsp.done) state_nxt = head.sweep_end ? BK_EMIT : BK_IDLE;
      BK_EMIT: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op_state = 1'b1;
    req.op = FOP_ADD;
    req.a = val_sum_r;
    req.b = prod_r;
    pop = 1'b0;
    clear_sums = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_MUL_V: begin
        req.op = FOP_MUL;
        req.a = head.point_value;
        req.b = head.coefficient;
      end
      BK_ADD_V: req.a = val_sum_r;
      BK_MUL_S: begin
        req.op = FOP_MUL;
        req.a = head.direction_value;
        req.b = head.coefficient;
      end
      BK_ADD_S: begin
        req.a = slp_sum_r;
        pop = rsp.done && !head.row_end && !head.sweep_end;
      end
      BK_SUB_LO: begin
        req.op = FOP_SUB;
        req.a = head.lower_bound;
        req.b = val_sum_r;
      end
      BK_SUB_HI: begin
        req.op = FOP_SUB;
        req.a = head.upper_bound;
        req.b = val_sum_r;
      end
      BK_DIV_LO: begin
        req.op = FOP_DIV;
        req.a = tmp_r;
        req.b = slp_sum_r;
      end
      BK_DIV_HI: begin
        req.op = FOP_DIV;
        req.a = tmp_r;
        req.b = slp_sum_r;
        clear_sums = rsp.done;
        pop = rsp.done && !head.sweep_end;
      end
      BK_ROW: begin
        op_state = 1'b0;
        clear_sums = !hit;
        pop = !hit && !head.sweep_end;
      end
      BK_EMIT: begin
        op_state = 1'b0;
        load_out = out_free;
        pop = out_free;
      end
      default: op_state = 1'b0;
    endcase
    req.start = op_state && !issued_r;
  end

  // datapath
  always_comb begin
    issued_nxt = req.start ? 1'b1 : (rsp.done ? 1'b0 : issued_r);
    prod_nxt = prod_r;
    tmp_nxt = tmp_r;
    val_sum_nxt = val_sum_r;
    slp_sum_nxt = slp_sum_r;
    fwd_nxt = fwd_r;
    bwd_nxt = bwd_r;
    if (rsp.done) begin
      case (state_r)
        BK_MUL_V, BK_MUL_S: prod_nxt = rsp.res;
        BK_ADD_V: val_sum_nxt = rsp.res;
        BK_ADD_S: slp_sum_nxt = rsp.res;
        BK_SUB_LO, BK_SUB_HI: tmp_nxt = rsp.res;
        BK_DIV_LO, BK_DIV_HI: begin
          if (fp_lt(rsp.res, POS_ZERO) && fp_lt(bwd_r, rsp.res)) bwd_nxt = rsp.res;
          if (fp_lt(POS_ZERO, rsp.res) && fp_lt(rsp.res, fwd_r)) fwd_nxt = rsp.res;
        end
        default: ;
      endcase
    end
    if (clear_sums) begin
      val_sum_nxt = POS_ZERO;
      slp_sum_nxt = POS_ZERO;
    end
    out_fwd_nxt = out_fwd_r;
    out_bwd_nxt = out_bwd_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (load_out) begin
      out_fwd_nxt = fwd_r;
      out_bwd_nxt = bwd_r;
      out_valid_nxt = 1'b1;
      fwd_nxt = EXT_POS;
      bwd_nxt = EXT_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      issued_r <= 1'b0;
      out_valid_r <= 1'b0;
      val_sum_r <= POS_ZERO;
      slp_sum_r <= POS_ZERO;
      fwd_r <= EXT_POS;
      bwd_r <= EXT_NEG;
    end else begin
      state_r <= state_nxt;
      issued_r <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      val_sum_r <= val_sum_nxt;
      slp_sum_r <= slp_sum_nxt;
      fwd_r <= fwd_nxt;
      bwd_r <= bwd_nxt;
    end
    prod_r <= prod_nxt;
    tmp_r <= tmp_nxt;
    out_fwd_r <= out_fwd_nxt;
    out_bwd_r <= out_bwd_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.step_forward = out_fwd_r;
  assign out_ch.step_backward = out_bwd_r;

endmodule

FILE: design/polytope_chord_extrema_unit.sv
// an entry without a row end takes two multiplies and two adds through the one shared
// fpu; a row end with distances adds two subtracts and two 56-step divides. one entry
// is worked on at a time; the two-entry input queue and the output register let both
// sides stall on their own.
// reset (synchronous, rst_n low): queue empty, no result pending, row sums +0,
// extremes +1e9 and -1e9.
module polytope_chord_extrema_unit
  import pce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pce_in_if.sink     in_ch,
  pce_out_if.source  out_ch
);

  logic head_valid, pop;
  pce_entry_t head;
  fpu_req_t req;
  fpu_rsp_t rsp;

  pce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pce_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  pce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .req        (req),
    .rsp        (rsp),
    .out_ch     (out_ch)
  );

endmodule
